### sv/led_dimmer_soft_ramp_current_limit_macros.svh
// Assertion macros shared by the LED dimmer RTL.
`ifndef LED_DIMMER_SOFT_RAMP_CURRENT_LIMIT_MACROS_SVH
`define LED_DIMMER_SOFT_RAMP_CURRENT_LIMIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LDSR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LDSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LDSR_ASSERT(label, clk, rst, prop, msg)
`define LDSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### sv/ldsr_pkg.sv
// Types, constants and helper functions of the LED dimmer.
`timescale 1ns / 1ps

package ldsr_pkg;

  localparam logic       ACTION_TICK         = 1'b0;
  localparam logic       ACTION_SET_LEVEL    = 1'b1;

  localparam logic [1:0] CFG_ON_LEVEL        = 2'd0;
  localparam logic [1:0] CFG_RAMP_PERIOD     = 2'd1;
  localparam logic [1:0] CFG_CURRENT_LIMIT   = 2'd2;

  localparam logic [6:0]  BUTTON_SAMPLE_TICKS = 7'd100;
  localparam logic [6:0]  LEVEL_MAX           = 7'd100;
  localparam logic [6:0]  ON_LEVEL_RESET      = 7'd50;
  localparam logic [15:0] RAMP_PERIOD_RESET   = 16'd10;
  localparam logic [15:0] CURRENT_LIMIT_RESET = 16'd4950;

  // ceil(2^26 / 25): exact quotient by 25 for any 21-bit dividend.
  localparam logic [21:0] RECIP_25            = 22'd2684355;

  typedef struct packed {
    logic        action;
    logic        button_pin;
    logic [15:0] measured_current_ma;
    logic [7:0]  level_value;
  } tick_item_t;

  typedef struct packed {
    logic [15:0] pwm_code;
    logic [6:0]  ramp_level;
    logic [6:0]  target_level;
    logic        lamp_on;
  } result_item_t;

  typedef struct packed {
    logic [6:0]  on_level;
    logic [15:0] ramp_period_ticks;
    logic [15:0] current_limit_ma;
  } cfg_t;

  function automatic logic [6:0] clip_level(input logic [7:0] value);
    return (value > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : value[6:0];
  endfunction

  // Computes level * 65535 / 100 as ((level * 65535) / 4) / 25.
  function automatic logic [15:0] pwm_of(input logic [6:0] level);
    logic [22:0] scaled;
    logic [20:0] quarter;
    logic [42:0] prod;
    scaled  = {level, 16'b0} - {16'b0, level};
    quarter = scaled[22:2];
    prod    = {22'b0, quarter} * {21'b0, RECIP_25};
    return prod[41:26];
  endfunction

endpackage

### sv/led_dimmer_soft_ramp_current_limit.sv
// Top level of the LED dimmer with soft ramp and current limit.
//
// Usage: tick_data carries one item per transfer (tick_valid high, tick_stall
// low). A tick item stands for one millisecond and brings the button pin and
// the measured LED current; a set-level item sets the target directly.
// Every accepted item yields exactly one result on result_data, transferred
// when result_valid is high and result_stall is low. The result gives the
// PWM code, ramp level, target level and lamp flag after that item.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data and
// are made while no item is in flight; cfg_ready is always high.
// An input transfer passes through the input register and then the result
// buffer before its result can be transferred. One item per cycle is
// sustained while the result buffer is not full, set by the single state
// update between the input register and the two-entry result buffer.
// Reset clears all timers and levels and loads the register defaults.
// When the receiver stalls, the result buffer absorbs two results and then
// tick_stall rises until a result is taken.
`timescale 1ns / 1ps

module led_dimmer_soft_ramp_current_limit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  ldsr_pkg::tick_item_t   tick_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ldsr_pkg::result_item_t result_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import ldsr_pkg::*;

  cfg_t         cfg;
  logic         buf_full;
  logic         res_valid;
  result_item_t res_data;

  ldsr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ldsr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick_data  (tick_data),
    .buf_full   (buf_full),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  ldsr_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (res_valid),
    .wr_data      (res_data),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

### sv/ldsr_cfg_regs.sv
// Configuration registers of the LED dimmer.
`timescale 1ns / 1ps

module ldsr_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output ldsr_pkg::cfg_t cfg
);
  import ldsr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_level          <= ON_LEVEL_RESET;
      cfg.ramp_period_ticks <= RAMP_PERIOD_RESET;
      cfg.current_limit_ma  <= CURRENT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ON_LEVEL:      cfg.on_level          <= cfg_data[6:0];
        CFG_RAMP_PERIOD:   cfg.ramp_period_ticks <= cfg_data;
        CFG_CURRENT_LIMIT: cfg.current_limit_ma  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/ldsr_core.sv
// Input register and per-item state update of the LED dimmer.
`timescale 1ns / 1ps
`include "led_dimmer_soft_ramp_current_limit_macros.svh"

module ldsr_core (
  input  logic                   clk,
  input  logic                   rst,
  input  ldsr_pkg::cfg_t         cfg,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  ldsr_pkg::tick_item_t   tick_data,
  input  logic                   buf_full,
  output logic                   res_valid,
  output ldsr_pkg::result_item_t res_data
);
  import ldsr_pkg::*;

  logic        hold_valid;
  tick_item_t  hold;
  logic        advance;

  logic [6:0]  sample_timer, sample_timer_next;
  logic [15:0] ramp_timer, ramp_timer_next;
  logic        last_pin, last_pin_next;
  logic        lamp_flag, lamp_flag_next;
  logic [6:0]  target_store, target_store_next;
  logic [6:0]  ramp_store, ramp_store_next;
  logic [15:0] pwm_store, pwm_store_next;
  logic [6:0]  sample_inc;
  logic [16:0] ramp_inc;

  assign advance    = hold_valid && !buf_full;
  assign tick_stall = hold_valid && buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (tick_valid && !tick_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      hold <= tick_data;
    end
  end

  assign sample_inc = sample_timer + 7'd1;
  assign ramp_inc   = {1'b0, ramp_timer} + 17'd1;

  // The button is sampled first; the ramp step then sees the new target.
  always_comb begin
    sample_timer_next = sample_timer;
    ramp_timer_next   = ramp_timer;
    last_pin_next     = last_pin;
    lamp_flag_next    = lamp_flag;
    target_store_next = target_store;
    ramp_store_next   = ramp_store;
    pwm_store_next    = pwm_store;
    if (advance) begin
      case (hold.action)
        ACTION_TICK: begin
          if (sample_inc >= BUTTON_SAMPLE_TICKS) begin
            sample_timer_next = '0;
            if (hold.button_pin != last_pin) begin
              last_pin_next = hold.button_pin;
              if (!hold.button_pin) begin
                lamp_flag_next    = 1'b1;
                target_store_next = clip_level({1'b0, cfg.on_level});
              end else begin
                lamp_flag_next    = 1'b0;
                target_store_next = '0;
              end
            end
          end else begin
            sample_timer_next = sample_inc;
          end
          if (ramp_inc >= {1'b0, cfg.ramp_period_ticks}) begin
            ramp_timer_next = '0;
            if (ramp_store != target_store_next) begin
              if (ramp_store < target_store_next) begin
                if (hold.measured_current_ma < cfg.current_limit_ma) begin
                  ramp_store_next = ramp_store + 7'd1;
                end else if (hold.measured_current_ma > cfg.current_limit_ma) begin
                  if (ramp_store != 7'd0) begin
                    ramp_store_next = ramp_store - 7'd1;
                  end
                end else begin
                  target_store_next = ramp_store;
                end
              end else begin
                ramp_store_next = ramp_store - 7'd1;
              end
              pwm_store_next = pwm_of(ramp_store_next);
            end
          end else begin
            ramp_timer_next = ramp_inc[15:0];
          end
        end
        ACTION_SET_LEVEL: begin
          target_store_next = clip_level(hold.level_value);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timer <= '0;
      ramp_timer   <= '0;
      last_pin     <= 1'b0;
      lamp_flag    <= 1'b0;
      target_store <= '0;
      ramp_store   <= '0;
      pwm_store    <= '0;
    end else begin
      sample_timer <= sample_timer_next;
      ramp_timer   <= ramp_timer_next;
      last_pin     <= last_pin_next;
      lamp_flag    <= lamp_flag_next;
      target_store <= target_store_next;
      ramp_store   <= ramp_store_next;
      pwm_store    <= pwm_store_next;
    end
  end

  assign res_valid             = advance;
  assign res_data.pwm_code     = pwm_store_next;
  assign res_data.ramp_level   = ramp_store_next;
  assign res_data.target_level = target_store_next;
  assign res_data.lamp_on      = lamp_flag_next;

  `LDSR_ASSERT(a_ramp_in_range, clk, rst, ramp_store <= LEVEL_MAX, "ramp level above 100")
  `LDSR_ASSERT(a_pwm_tracks_ramp, clk, rst, pwm_store == pwm_of(ramp_store), "pwm code stale")
  `LDSR_ASSERT_NEXT(a_ramp_holds_idle, clk, rst, !advance, $stable(ramp_store), "ramp drift")

endmodule

### sv/ldsr_out_buf.sv
// Two-entry result buffer that decouples the result channel from the core.
`timescale 1ns / 1ps
`include "led_dimmer_soft_ramp_current_limit_macros.svh"

module ldsr_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  ldsr_pkg::result_item_t wr_data,
  output logic                   full,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ldsr_pkg::result_item_t result_data
);
  import ldsr_pkg::*;

  result_item_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign result_valid = (count != 2'd0);
  assign full         = (count == 2'd2);
  assign pop          = result_valid && !result_stall;
  assign result_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `LDSR_ASSERT(a_no_write_when_full, clk, rst, !(wr_en && full), "write into a full result buffer")
  `LDSR_ASSERT_NEXT(a_stalled_head_kept, clk, rst, result_valid && result_stall, result_valid && $stable(rd_ptr), "stalled result lost")

endmodule

### dv/led_dimmer_soft_ramp_current_limit_tb.sv
// Self-checking testbench of the LED dimmer: a directed table, then random phases.
`timescale 1ns / 1ps

module led_dimmer_soft_ramp_current_limit_tb;
  import ldsr_pkg::*;

  typedef struct {
    bit           typed;
    result_item_t want;
  } answer_t;

  typedef struct {
    tick_item_t   item;
    bit           typed;
    result_item_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         tick_valid;
  logic         tick_stall;
  tick_item_t   tick_data;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_data;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  // Predictor state and its copy of the registers.
  cfg_t         dimmer_cfg;
  logic [6:0]   samp_cnt;
  logic [15:0]  ramp_cnt;
  logic         pin_seen;
  logic         lamp_q;
  logic [6:0]   target_q;
  logic [6:0]   ramp_q;
  logic [15:0]  pwm_q;

  answer_t      answer_q[$];
  result_item_t result_q[$];
  stim_row_t    directed_rows[$];
  cfg_t         phase_cfg[6];

  int           errors = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  int           stall_left = 0;
  logic         pin_level = 1'b1;
  int           pin_run = 150;

  always #10 clk = ~clk;

  led_dimmer_soft_ramp_current_limit DUT (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick_data    (tick_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic logic [6:0] clip_to_max(input logic [7:0] v);
    return (v > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : v[6:0];
  endfunction

  function automatic logic [15:0] duty_code(input logic [6:0] level);
    int unsigned scaled;
    scaled = {25'b0, level};
    scaled = scaled * 32'd65535 / 32'd100;
    return scaled[15:0];
  endfunction

  function automatic void step_ramp(input logic [15:0] curr);
    if (ramp_q != target_q) begin
      if (ramp_q < target_q) begin
        if (curr < dimmer_cfg.current_limit_ma) begin
          ramp_q = ramp_q + 7'd1;
        end else if (curr > dimmer_cfg.current_limit_ma) begin
          if (ramp_q != 7'd0) begin
            ramp_q = ramp_q - 7'd1;
          end
        end else begin
          target_q = ramp_q;
        end
      end else begin
        ramp_q = ramp_q - 7'd1;
      end
      pwm_q = duty_code(ramp_q);
    end
  endfunction

  function automatic result_item_t dimmer_after(input tick_item_t it);
    result_item_t r;
    logic [16:0]  next_ramp_cnt;
    if (it.action == ACTION_TICK) begin
      samp_cnt = samp_cnt + 7'd1;
      if (samp_cnt >= BUTTON_SAMPLE_TICKS) begin
        samp_cnt = 7'd0;
        if (it.button_pin != pin_seen) begin
          if (it.button_pin == 1'b0) begin
            lamp_q   = 1'b1;
            target_q = clip_to_max({1'b0, dimmer_cfg.on_level});
          end else begin
            lamp_q   = 1'b0;
            target_q = 7'd0;
          end
          pin_seen = it.button_pin;
        end
      end
      next_ramp_cnt = {1'b0, ramp_cnt} + 17'd1;
      if (next_ramp_cnt >= {1'b0, dimmer_cfg.ramp_period_ticks}) begin
        ramp_cnt = 16'd0;
        step_ramp(it.measured_current_ma);
      end else begin
        ramp_cnt = next_ramp_cnt[15:0];
      end
    end else begin
      target_q = clip_to_max(it.level_value);
    end
    r.pwm_code     = pwm_q;
    r.ramp_level   = ramp_q;
    r.target_level = target_q;
    r.lamp_on      = lamp_q;
    return r;
  endfunction

  function automatic void add_row(input logic act, input logic pin, input logic [15:0] curr,
                                  input logic [7:0] lvl, input bit typed,
                                  input logic [15:0] pwm, input logic [6:0] ramp,
                                  input logic [6:0] tgt, input logic lamp);
    stim_row_t row;
    row.item.action              = act;
    row.item.button_pin          = pin;
    row.item.measured_current_ma = curr;
    row.item.level_value         = lvl;
    row.typed                    = typed;
    row.want.pwm_code            = pwm;
    row.want.ramp_level          = ramp;
    row.want.target_level        = tgt;
    row.want.lamp_on             = lamp;
    directed_rows.push_back(row);
  endfunction

  function automatic tick_item_t random_item();
    tick_item_t  it;
    logic [15:0] lim;
    lim                    = dimmer_cfg.current_limit_ma;
    it.level_value         = 8'($urandom_range(0, 255));
    it.button_pin          = 1'($urandom_range(0, 1));
    it.measured_current_ma = 16'($urandom);
    if ($urandom_range(0, 99) < 6) begin
      it.action = ACTION_SET_LEVEL;
      if ($urandom_range(0, 1) == 0) begin
        it.level_value = 8'($urandom_range(0, 100));
      end
      return it;
    end
    it.action = ACTION_TICK;
    if (pin_run == 0) begin
      pin_level = ~pin_level;
      pin_run   = $urandom_range(60, 300);
    end else begin
      pin_run = pin_run - 1;
    end
    if ($urandom_range(0, 99) >= 3) begin
      it.button_pin = pin_level;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (lim != 16'd0) begin
          it.measured_current_ma = 16'($urandom_range(0, lim - 16'd1));
        end
      end
      5, 6: it.measured_current_ma = lim;
      7: begin
        if (lim != 16'hFFFF) begin
          it.measured_current_ma = lim + 16'd1;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input cfg_t c);
    logic [8:0] junk;
    junk = 9'($urandom_range(0, 511));
    put_reg(CFG_ON_LEVEL, {junk, c.on_level});
    put_reg(CFG_RAMP_PERIOD, c.ramp_period_ticks);
    put_reg(CFG_CURRENT_LIMIT, c.current_limit_ma);
    cfg_valid  <= 1'b0;
    dimmer_cfg = c;
  endtask

  task automatic send_one(input tick_item_t it, input bit typed, input result_item_t want);
    answer_t a;
    if ($urandom_range(0, 99) < gap_pct) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    a.typed = typed;
    a.want  = want;
    answer_q.push_back(a);
    tick_valid <= 1'b1;
    tick_data  <= it;
    do @(posedge clk); while (tick_stall);
  endtask

  task automatic wait_idle();
    tick_valid <= 1'b0;
    while (answer_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stalls come in bursts whose length is drawn at random.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 6);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    answer_t      a;
    result_item_t predicted;
    result_item_t exp_r;
    if (!rst) begin
      if (tick_valid && !tick_stall) begin
        predicted = dimmer_after(tick_data);
        a = answer_q.pop_front();
        result_q.push_back(a.typed ? a.want : predicted);
      end
      if (result_valid && !result_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, result_data);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (result_data.pwm_code !== exp_r.pwm_code) begin
            $display("%0t: pwm_code expected %0d actual %0d",
                     $time, exp_r.pwm_code, result_data.pwm_code);
            errors++;
          end
          if (result_data.ramp_level !== exp_r.ramp_level) begin
            $display("%0t: ramp_level expected %0d actual %0d",
                     $time, exp_r.ramp_level, result_data.ramp_level);
            errors++;
          end
          if (result_data.target_level !== exp_r.target_level) begin
            $display("%0t: target_level expected %0d actual %0d",
                     $time, exp_r.target_level, result_data.target_level);
            errors++;
          end
          if (result_data.lamp_on !== exp_r.lamp_on) begin
            $display("%0t: lamp_on expected %0d actual %0d",
                     $time, exp_r.lamp_on, result_data.lamp_on);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    cfg_t         c;
    result_item_t none;
    int           phase_items;
    none         = '0;
    rst          = 1'b1;
    tick_valid   = 1'b0;
    tick_data    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ON_LEVEL;
    cfg_data     = 16'd0;
    dimmer_cfg   = '{ON_LEVEL_RESET, RAMP_PERIOD_RESET, CURRENT_LIMIT_RESET};
    samp_cnt     = 7'd0;
    ramp_cnt     = 16'd0;
    pin_seen     = 1'b0;
    lamp_q       = 1'b0;
    target_q     = 7'd0;
    ramp_q       = 7'd0;
    pwm_q        = 16'd0;

    // Step every tick with a low limit so the directed rows reach every ramp case.
    add_row(ACTION_TICK,      1'b1, 16'd0,     8'd255, 1, 16'd0,   7'd0, 7'd0,   1'b0);
    add_row(ACTION_SET_LEVEL, 1'b0, 16'hFFFF,  8'd255, 1, 16'd0,   7'd0, 7'd100, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd0,     8'd0,   1, 16'd655, 7'd1, 7'd100, 1'b0);
    add_row(ACTION_TICK,      1'b0, 16'd999,   8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'hFFFF,  8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd1001,  8'd0,   1, 16'd0,   7'd0, 7'd100, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'hFFFF,  8'd0,   1, 16'd0,   7'd0, 7'd100, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd1000,  8'd0,   1, 16'd0,   7'd0, 7'd0,   1'b0);
    add_row(ACTION_SET_LEVEL, 1'b1, 16'd0,     8'd101, 1, 16'd0,   7'd0, 7'd100, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd0,     8'd77,  0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b0, 16'd500,   8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd999,   8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_SET_LEVEL, 1'b0, 16'd1000,  8'd100, 0, '0, '0, '0, 1'b0);
    add_row(ACTION_SET_LEVEL, 1'b1, 16'd0,     8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'hFFFF,  8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd0,     8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_SET_LEVEL, 1'b1, 16'd0,     8'd1,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd1000,  8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_SET_LEVEL, 1'b1, 16'd0,     8'd2,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd1000,  8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd0,     8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_SET_LEVEL, 1'b1, 16'd0,     8'd0,   0, '0, '0, '0, 1'b0);
    add_row(ACTION_TICK,      1'b1, 16'd0,     8'd0,   1, 16'd0,   7'd0, 7'd0,   1'b0);

    phase_cfg[0] = '{7'd50,  16'd10,    16'd4950};
    phase_cfg[1] = '{7'd100, 16'd0,     16'hFFFF};
    phase_cfg[2] = '{7'd127, 16'd1,     16'd0};
    phase_cfg[3] = '{7'd0,   16'd3,     16'd2000};
    phase_cfg[4] = '{7'd77,  16'hFFFF,  16'd4950};
    phase_cfg[5] = '{7'd100, 16'd0,     16'd30000};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    c = '{7'd100, 16'd0, 16'd1000};
    load_config(c);
    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed_rows[i]) begin
      send_one(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      // Every phase change waits for the block to drain before the registers move.
      wait_idle();
      load_config(phase_cfg[p]);
      if (p == 5) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      end
      phase_items = 185;
      for (int k = 0; k < phase_items; k++) begin
        send_one(random_item(), 0, none);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
